/* rtl/gea_pkg.sv */
// Shared types, constants and helpers for the gamepad edge/autorepeat block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gea_pkg;

  // Slot and channel counts
  localparam int NSLOTS   = 22;
  localparam int NCHAN    = 20;
  localparam int NBUTTONS = 12;
  localparam int NAXES    = 4;

  // Slot positions of the alias sources and targets
  localparam int SLOT_CIRCLE = 7;
  localparam int SLOT_CROSS  = 8;
  localparam int SLOT_ENTER  = 12;
  localparam int SLOT_CANCEL = 13;

  // Repeat counter width (valid from 4 to 8)
  localparam int CNT_W = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTER_ON_CIRCLE = 3'd0,
    CFG_STICK_CENTER    = 3'd1,
    CFG_STICK_THRESHOLD = 3'd2,
    CFG_REPEAT_DELAY    = 3'd3,
    CFG_REPEAT_RELOAD   = 3'd4
  } cfg_idx_t;

  // Register reset values
  localparam logic       RST_ENTER_ON_CIRCLE = 1'b1;
  localparam logic [7:0] RST_STICK_CENTER    = 8'd128;
  localparam logic [7:0] RST_STICK_THRESHOLD = 8'd64;
  localparam logic [3:0] RST_REPEAT_DELAY    = 4'd10;
  localparam logic [3:0] RST_REPEAT_RELOAD   = 4'd6;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [NSLOTS-1:0] mask_t;

  // Repeat timing handed to every lane
  typedef struct packed {
    logic [3:0] delay;
    logic [3:0] reload;
  } rep_cfg_t;

  // Per-channel findings of one lane
  typedef struct packed {
    logic held;
    logic pressed;
    logic released;
    logic rpt;
    logic fast;
  } lane_out_t;

  // One result word
  typedef struct packed {
    mask_t held;
    mask_t pressed;
    mask_t released;
    mask_t rpt;
    mask_t fast;
  } result_t;

  // Increment that sticks at the top count
  function automatic cnt_t sat_inc(cnt_t c);
    return (c == CNT_MAX) ? c : c + cnt_t'(1);
  endfunction

endpackage

`default_nettype wire

/* rtl/gamepad_edge_autorepeat_top.sv */
// Top level of the gamepad edge detector with slow and fast autorepeat.
// Depends on gea_pkg, gea_axis, gea_lane and gea_merge.
`timescale 1ns / 1ps
`default_nettype none

// One poll word is taken per clock cycle while in_stall is low. Twenty
// channel lanes (twelve buttons and eight stick directions) update their
// level and repeat counters side by side in the accepting cycle, so
// throughput is one word per cycle as long as the result side keeps up. The
// result word appears on the next cycle in a two-entry output buffer
// (register plus skid): in the register, or in the skid entry while a result
// waits; in_stall rises only when both are full. Configuration writes take
// effect on the next cycle and should be made while no word is in flight.
module gamepad_edge_autorepeat_top
  import gea_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // poll words
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [11:0]           in_button_bits,
  input  wire logic [7:0]            in_left_x,
  input  wire logic [7:0]            in_left_y,
  input  wire logic [7:0]            in_right_x,
  input  wire logic [7:0]            in_right_y,
  // result words
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [NSLOTS-1:0]          out_held_mask,
  output logic [NSLOTS-1:0]          out_pressed_mask,
  output logic [NSLOTS-1:0]          out_released_mask,
  output logic [NSLOTS-1:0]          out_repeat_mask,
  output logic [NSLOTS-1:0]          out_fast_repeat_mask
);

  logic       enter_on_circle_r;
  logic [7:0] stick_center_r;
  logic [7:0] stick_threshold_r;
  logic [3:0] repeat_delay_r;
  logic [3:0] repeat_reload_r;

  logic                  in_fire;
  logic                  busy;
  logic [NCHAN-1:0]      levels;
  logic [NAXES-1:0][1:0] dirs;
  logic [NAXES-1:0][7:0] axis_pos;
  rep_cfg_t              rep_cfg;
  lane_out_t [NCHAN-1:0] lane_res;
  result_t               out_word;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enter_on_circle_r <= RST_ENTER_ON_CIRCLE;
      stick_center_r    <= RST_STICK_CENTER;
      stick_threshold_r <= RST_STICK_THRESHOLD;
      repeat_delay_r    <= RST_REPEAT_DELAY;
      repeat_reload_r   <= RST_REPEAT_RELOAD;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ENTER_ON_CIRCLE: enter_on_circle_r <= cfg_wdata[0];
        CFG_STICK_CENTER:    stick_center_r    <= cfg_wdata[7:0];
        CFG_STICK_THRESHOLD: stick_threshold_r <= cfg_wdata[7:0];
        CFG_REPEAT_DELAY:    repeat_delay_r    <= cfg_wdata[3:0];
        CFG_REPEAT_RELOAD:   repeat_reload_r   <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  assign rep_cfg.delay  = repeat_delay_r;
  assign rep_cfg.reload = repeat_reload_r;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;

  // Axis order follows slot order: left up/down, left left/right, then right
  assign axis_pos[0] = in_left_y;
  assign axis_pos[1] = in_left_x;
  assign axis_pos[2] = in_right_y;
  assign axis_pos[3] = in_right_x;

  for (genvar a = 0; a < NAXES; a++) begin : g_axis
    gea_axis u_axis (
      .pos       (axis_pos[a]),
      .center    (stick_center_r),
      .threshold (stick_threshold_r),
      .dir       (dirs[a])
    );
  end

  assign levels = {dirs, in_button_bits};

  // Channel lanes
  for (genvar ch = 0; ch < NCHAN; ch++) begin : g_lane
    gea_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .step  (in_fire),
      .level (levels[ch]),
      .cfg   (rep_cfg),
      .res   (lane_res[ch])
    );
  end

  gea_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .lanes           (lane_res),
    .enter_on_circle (enter_on_circle_r),
    .in_fire         (in_fire),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_word        (out_word)
  );

  assign out_held_mask        = out_word.held;
  assign out_pressed_mask     = out_word.pressed;
  assign out_released_mask    = out_word.released;
  assign out_repeat_mask      = out_word.rpt;
  assign out_fast_repeat_mask = out_word.fast;

endmodule

`default_nettype wire

/* rtl/gea_axis.sv */
// Stick axis decoder: turns one 8-bit position into low/high direction bits.
// Depends on gea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gea_axis
  import gea_pkg::*;
(
  input  wire logic [7:0] pos,
  input  wire logic [7:0] center,
  input  wire logic [7:0] threshold,
  output logic      [1:0] dir     // [0] below band, [1] above band
);

  logic [8:0] pos_plus_thr;
  logic [8:0] ctr_plus_thr;

  // 9-bit sums keep the band edges exact past 0 and 255
  assign pos_plus_thr = {1'b0, pos} + {1'b0, threshold};
  assign ctr_plus_thr = {1'b0, center} + {1'b0, threshold};

  always_comb begin
    dir = 2'b00;
    if (pos_plus_thr < {1'b0, center}) begin
      dir[0] = 1'b1;
    end else if ({1'b0, pos} > ctr_plus_thr) begin
      dir[1] = 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/gea_lane.sv */
// One physical channel: previous level, edge detect, slow and fast repeat counters.
// Depends on gea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gea_lane
  import gea_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,     // a word is accepted this cycle
  input  wire logic      level,
  input  wire rep_cfg_t  cfg,
  output lane_out_t      res
);

  logic prev_r;
  cnt_t slow_r, slow_nxt;
  cnt_t fast_r, fast_nxt;
  cnt_t delay_c, reload_c;
  logic slow_hit, fast_hit, pressed;
  cnt_t slow_base, fast_base;

  assign delay_c  = cnt_t'(cfg.delay);
  assign reload_c = cnt_t'(cfg.reload);

  // Repeat decisions on the current counts
  assign slow_hit = level && (slow_r >= delay_c);
  assign fast_hit = level && (fast_r >= delay_c);
  assign pressed  = level && !prev_r;

  assign slow_base = slow_hit ? reload_c : slow_r;
  assign fast_base = fast_hit ? delay_c  : fast_r;
  assign slow_nxt  = level ? sat_inc(slow_base) : '0;
  assign fast_nxt  = level ? sat_inc(fast_base) : '0;

  assign res.held     = level;
  assign res.pressed  = pressed;
  assign res.released = !level && prev_r;
  assign res.rpt      = slow_hit || pressed;
  assign res.fast     = fast_hit || pressed;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      slow_r <= '0;
      fast_r <= '0;
    end else if (step) begin
      prev_r <= level;
      slow_r <= slow_nxt;
      fast_r <= fast_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/gea_merge.sv */
// Merge stage: packs lane findings into slot order, fills the enter/cancel
// alias slots and holds results in an output register with a skid entry.
// Depends on gea_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gea_merge
  import gea_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lane_out_t [NCHAN-1:0] lanes,
  input  wire logic                  enter_on_circle,
  input  wire logic                  in_fire,
  output logic                       busy,      // skid entry occupied
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output result_t                    out_word
);

  result_t packed_w;
  result_t res_w;
  result_t out_r, skid_r;
  logic    out_vld_r, skid_vld_r;
  logic    out_fire;

  // Channel to slot: buttons keep their place, sticks sit past the alias slots
  always_comb begin
    packed_w = '0;
    for (int ch = 0; ch < NCHAN; ch++) begin
      if (ch < NBUTTONS) begin
        packed_w.held[ch]     = lanes[ch].held;
        packed_w.pressed[ch]  = lanes[ch].pressed;
        packed_w.released[ch] = lanes[ch].released;
        packed_w.rpt[ch]      = lanes[ch].rpt;
        packed_w.fast[ch]     = lanes[ch].fast;
      end else begin
        packed_w.held[ch+2]     = lanes[ch].held;
        packed_w.pressed[ch+2]  = lanes[ch].pressed;
        packed_w.released[ch+2] = lanes[ch].released;
        packed_w.rpt[ch+2]      = lanes[ch].rpt;
        packed_w.fast[ch+2]     = lanes[ch].fast;
      end
    end
  end

  // Alias slots copy circle or cross in every mask
  function automatic mask_t alias_mask(mask_t m, logic eoc);
    mask_t r;
    r = m;
    r[SLOT_ENTER]  = eoc ? m[SLOT_CIRCLE] : m[SLOT_CROSS];
    r[SLOT_CANCEL] = eoc ? m[SLOT_CROSS]  : m[SLOT_CIRCLE];
    return r;
  endfunction

  always_comb begin
    res_w.held     = alias_mask(packed_w.held,     enter_on_circle);
    res_w.pressed  = alias_mask(packed_w.pressed,  enter_on_circle);
    res_w.released = alias_mask(packed_w.released, enter_on_circle);
    res_w.rpt      = alias_mask(packed_w.rpt,      enter_on_circle);
    res_w.fast     = alias_mask(packed_w.fast,     enter_on_circle);
  end

  assign out_fire  = out_vld_r && !out_stall;
  assign busy      = skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_word  = out_r;

  // Output register plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_fire) begin
        skid_vld_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_vld_r && !out_fire) begin
        skid_vld_r <= 1'b1;
      end
      out_vld_r <= 1'b1;
    end else if (out_fire) begin
      out_vld_r <= 1'b0;
    end
  end

  // Payload moves need no reset
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (in_fire) begin
      if (out_vld_r && !out_fire) begin
        skid_r <= res_w;
      end else begin
        out_r <= res_w;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/gea_checker.sv */
// Port-level checker for the gamepad edge/autorepeat top, with its bind.
// Depends on gea_pkg and gamepad_edge_autorepeat_top.
`timescale 1ns / 1ps
`default_nettype none

module gea_checker
  import gea_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [NSLOTS-1:0] out_held_mask,
  input wire logic [NSLOTS-1:0] out_pressed_mask,
  input wire logic [NSLOTS-1:0] out_released_mask,
  input wire logic [NSLOTS-1:0] out_repeat_mask,
  input wire logic [NSLOTS-1:0] out_fast_repeat_mask
);

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A waiting word is not withdrawn
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // Edges agree with the level
  a_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pressed_mask & ~out_held_mask) == '0) &&
                  ((out_released_mask & out_held_mask) == '0))
    else $error("edge mask disagrees with held mask");

  // A press always shows on both repeat masks, and repeats need a held slot
  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_pressed_mask & ~out_repeat_mask) == '0) &&
                  ((out_pressed_mask & ~out_fast_repeat_mask) == '0) &&
                  (((out_repeat_mask | out_fast_repeat_mask) & ~out_held_mask) == '0))
    else $error("repeat mask inconsistent");

  // In the held mask, enter XOR cancel equals circle XOR cross
  a_alias: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_held_mask[SLOT_ENTER] ^ out_held_mask[SLOT_CANCEL]) ==
                   (out_held_mask[SLOT_CIRCLE] ^ out_held_mask[SLOT_CROSS])))
    else $error("alias slots do not follow circle/cross");

endmodule

bind gamepad_edge_autorepeat_top gea_checker u_gea_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_held_mask        (out_held_mask),
  .out_pressed_mask     (out_pressed_mask),
  .out_released_mask    (out_released_mask),
  .out_repeat_mask      (out_repeat_mask),
  .out_fast_repeat_mask (out_fast_repeat_mask)
);

`default_nettype wire
